### rtl/hfl_pkg.sv
// Package for the handle free-list allocator.
// Holds field widths, operation and status codes and the control state type.
// Has no dependencies; every other file of the block refers to it by scoped names.
package hfl_pkg;

  localparam int unsigned HANDLE_W = 9;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CAP_W    = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_QUERY   = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_NO_TEMPLATE = 3'd1,
    STAT_FULL        = 3'd2,
    STAT_RANGE       = 3'd3,
    STAT_DEAD        = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

### rtl/hfl_req_if.sv
// Request channel of the handle free-list allocator.
// Depends on hfl_pkg for the field widths.
interface hfl_req_if;
  logic                         valid;
  logic                         ready;
  logic [hfl_pkg::MODE_W-1:0]   mode;
  logic [hfl_pkg::HANDLE_W-1:0] handle;
  logic                         template_valid;

  modport source (output valid, mode, handle, template_valid, input ready);
  modport sink   (input valid, mode, handle, template_valid, output ready);
endinterface

### rtl/hfl_rsp_if.sv
// Response channel of the handle free-list allocator.
// Depends on hfl_pkg for the field widths.
interface hfl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [hfl_pkg::HANDLE_W-1:0]   handle_out;
  logic                           ok;
  logic [hfl_pkg::STATUS_W-1:0]   status;

  modport source (output valid, handle_out, ok, status, input ready);
  modport sink   (input valid, handle_out, ok, status, output ready);
endinterface

### rtl/hfl_cfg_if.sv
// Configuration write channel of the handle free-list allocator (capacity).
// Depends on hfl_pkg for the register width.
interface hfl_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [hfl_pkg::CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/handle_free_list_allocator.sv
// Handle free-list allocator: LIFO reuse of released handles, then fresh issue.
// Depends on hfl_pkg and the interfaces hfl_req_if, hfl_rsp_if and hfl_cfg_if.
//
//   channel  direction  payload                        accepted when
//   req      in         mode, handle, template_valid   valid && ready
//   rsp      out        handle_out, ok, status         valid && ready
//   cfg      in         data (capacity)                valid && ready
//
// Each request passes a read step, which reads the free stack and the alive map, which
// are synchronous memories, and then a decision step, which decides, writes back and
// loads the response register. A response waiting in that register does not block the
// next request from being taken; it stalls only the decision step after it.
// Reset needs no clearing pass: alive entries are read only below the issue count.
module handle_free_list_allocator #(
  parameter int unsigned MAX_HANDLES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hfl_req_if.sink          req,
  hfl_rsp_if.source        rsp,
  hfl_cfg_if.sink          cfg
);

  localparam int unsigned AW = $clog2(MAX_HANDLES);
  localparam int unsigned CW = $clog2(MAX_HANDLES + 1);
  localparam int unsigned XW =
    ((CW > hfl_pkg::HANDLE_W) ? CW : hfl_pkg::HANDLE_W) + 1;

  // Memories
  logic [hfl_pkg::HANDLE_W-1:0] stack_mem [MAX_HANDLES];
  logic                         alive_mem [MAX_HANDLES];

  // Control state
  hfl_pkg::state_e              state_q, state_d;
  logic [CW-1:0]                depth_q, depth_d;
  logic [CW-1:0]                issued_q, issued_d;
  logic [hfl_pkg::CAP_W-1:0]    cap_q;
  logic                         rsp_valid_q, rsp_valid_d;

  // Captured request and registered read data
  logic [hfl_pkg::MODE_W-1:0]   mode_q;
  logic [hfl_pkg::HANDLE_W-1:0] handle_q;
  logic                         tv_q;
  logic [hfl_pkg::HANDLE_W-1:0] stack_rd_q;
  logic                         alive_rd_q;

  // Response register
  logic [hfl_pkg::HANDLE_W-1:0] rsp_handle_q;
  logic                         rsp_ok_q;
  hfl_pkg::status_e             rsp_status_q;

  logic                         req_fire, exec_done;
  logic [hfl_pkg::HANDLE_W-1:0] res_handle;
  logic                         res_ok;
  hfl_pkg::status_e             res_status;
  logic                         stack_we, alive_we, alive_wd;
  logic [AW-1:0]                stack_wa, alive_wa;
  logic [hfl_pkg::HANDLE_W-1:0] stack_wd;
  logic [XW-1:0]                cap_eff, handle_x, issued_x;
  logic [hfl_pkg::HANDLE_W-1:0] handle_m1, stack_id_m1;

  assign req_fire  = req.valid && req.ready;
  assign exec_done = (state_q == hfl_pkg::S_EXEC) && (!rsp_valid_q || rsp.ready);

  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid_q;
  assign rsp.handle_out = rsp_handle_q;
  assign rsp.ok         = rsp_ok_q;
  assign rsp.status     = rsp_status_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hfl_pkg::S_IDLE: if (req_fire) state_d = hfl_pkg::S_EXEC;
      hfl_pkg::S_EXEC: if (exec_done) state_d = hfl_pkg::S_IDLE;
      default:         state_d = hfl_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    req.ready = (state_q == hfl_pkg::S_IDLE);
  end

  assign cap_eff  = (XW'(cap_q) > XW'(MAX_HANDLES)) ? XW'(MAX_HANDLES) : XW'(cap_q);
  assign handle_x = XW'(handle_q);
  assign issued_x = XW'(issued_q);
  assign handle_m1   = handle_q - hfl_pkg::HANDLE_W'(1);
  assign stack_id_m1 = stack_rd_q - hfl_pkg::HANDLE_W'(1);

  // Decision and write-back
  always_comb begin
    res_handle = '0;
    res_ok     = 1'b0;
    res_status = hfl_pkg::STAT_RANGE;
    depth_d    = depth_q;
    issued_d   = issued_q;
    stack_we   = 1'b0;
    stack_wa   = AW'(depth_q);
    stack_wd   = handle_q;
    alive_we   = 1'b0;
    alive_wa   = AW'(handle_m1);
    alive_wd   = 1'b0;
    unique case (mode_q)
      hfl_pkg::MODE_ALLOC: begin
        if (!tv_q) begin
          res_status = hfl_pkg::STAT_NO_TEMPLATE;
        end else if (depth_q != '0) begin
          res_handle = stack_rd_q;
          res_ok     = 1'b1;
          res_status = hfl_pkg::STAT_OK;
          depth_d    = depth_q - CW'(1);
          alive_we   = 1'b1;
          alive_wa   = AW'(stack_id_m1);
          alive_wd   = 1'b1;
        end else if (issued_x < cap_eff) begin
          res_handle = hfl_pkg::HANDLE_W'(issued_q + CW'(1));
          res_ok     = 1'b1;
          res_status = hfl_pkg::STAT_OK;
          issued_d   = issued_q + CW'(1);
          alive_we   = 1'b1;
          alive_wa   = AW'(issued_q);
          alive_wd   = 1'b1;
        end else begin
          res_status = hfl_pkg::STAT_FULL;
        end
      end
      hfl_pkg::MODE_RELEASE, hfl_pkg::MODE_QUERY: begin
        if (handle_q == '0 || handle_x > issued_x || handle_x > XW'(MAX_HANDLES)) begin
          res_status = hfl_pkg::STAT_RANGE;
        end else if (!alive_rd_q) begin
          res_status = hfl_pkg::STAT_DEAD;
        end else if (mode_q == hfl_pkg::MODE_RELEASE && depth_q >= CW'(MAX_HANDLES)) begin
          res_status = hfl_pkg::STAT_FULL;
        end else begin
          res_handle = handle_q;
          res_ok     = 1'b1;
          res_status = hfl_pkg::STAT_OK;
          if (mode_q == hfl_pkg::MODE_RELEASE) begin
            depth_d  = depth_q + CW'(1);
            stack_we = 1'b1;
            alive_we = 1'b1;
          end
        end
      end
      default: begin
        res_status = hfl_pkg::STAT_RANGE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (exec_done) begin
      rsp_valid_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hfl_pkg::S_IDLE;
      depth_q     <= '0;
      issued_q    <= '0;
      cap_q       <= hfl_pkg::CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (exec_done) begin
        depth_q  <= depth_d;
        issued_q <= issued_d;
      end
      if (cfg.valid && cfg.ready) begin
        cap_q <= cfg.data;
      end
    end
  end

  // Request capture and memory reads; the reads see every earlier write-back
  // because the decision cycle always ends before the next request is taken.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mode_q     <= req.mode;
      handle_q   <= req.handle;
      tv_q       <= req.template_valid;
      stack_rd_q <= stack_mem[AW'(depth_q - CW'(1))];
      alive_rd_q <= alive_mem[AW'(req.handle - hfl_pkg::HANDLE_W'(1))];
    end
    if (exec_done) begin
      rsp_handle_q <= res_handle;
      rsp_ok_q     <= res_ok;
      rsp_status_q <= res_status;
      if (stack_we) begin
        stack_mem[stack_wa] <= stack_wd;
      end
      if (alive_we) begin
        alive_mem[alive_wa] <= alive_wd;
      end
    end
  end

endmodule

### test/handle_free_list_allocator_tb.sv
// Self-checking testbench for handle_free_list_allocator: allocate, release and query traffic
// with random idling on both channels, checked against an in-bench model of the handle store.
// Depends on hfl_pkg, the interfaces hfl_req_if, hfl_rsp_if and hfl_cfg_if, and the block itself.
`timescale 1ns / 1ps

module handle_free_list_allocator_tb;

  localparam int unsigned MAX_H = 256;
  localparam logic [hfl_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [hfl_pkg::MODE_W-1:0]   mode;
    logic [hfl_pkg::HANDLE_W-1:0] handle;
    logic                         tmpl;
  } handle_req_t;

  typedef struct packed {
    logic [hfl_pkg::HANDLE_W-1:0] handle;
    logic                         ok;
    hfl_pkg::status_e             status;
  } handle_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hfl_req_if req_ch ();
  hfl_rsp_if rsp_ch ();
  hfl_cfg_if cfg_ch ();

  handle_free_list_allocator #(
    .MAX_HANDLES(MAX_H)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch),
    .rsp   (rsp_ch),
    .cfg   (cfg_ch)
  );

  // Shadow of the allocator state, updated as each transaction is accepted.
  logic [hfl_pkg::CAP_W-1:0]    capacity_reg = hfl_pkg::CAP_RESET;
  logic [hfl_pkg::HANDLE_W-1:0] free_lifo [MAX_H];
  int unsigned                  lifo_depth = 0;
  int unsigned                  issued_hw = 0;
  bit                           live_map [MAX_H];

  handle_req_t req_backlog [$];
  handle_rsp_t awaited_rsp [$];
  bit          req_fired = 1'b0;
  bit          steady_run = 1'b0;
  int unsigned err_count = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic handle_rsp_t apply_handle_op(handle_req_t r);
    handle_rsp_t o;
    int unsigned limit;
    o.handle = '0;
    o.ok     = 1'b0;
    o.status = hfl_pkg::STAT_RANGE;
    limit = (capacity_reg > MAX_H) ? MAX_H : capacity_reg;
    case (r.mode)
      hfl_pkg::MODE_ALLOC: begin
        if (!r.tmpl) begin
          o.status = hfl_pkg::STAT_NO_TEMPLATE;
        end else if (lifo_depth > 0) begin
          // The most recently released handle goes out first.
          lifo_depth--;
          o.handle = free_lifo[lifo_depth];
          live_map[o.handle - 1] = 1'b1;
          o.ok = 1'b1;
          o.status = hfl_pkg::STAT_OK;
        end else if (issued_hw < limit) begin
          issued_hw++;
          o.handle = hfl_pkg::HANDLE_W'(issued_hw);
          live_map[issued_hw - 1] = 1'b1;
          o.ok = 1'b1;
          o.status = hfl_pkg::STAT_OK;
        end else begin
          o.status = hfl_pkg::STAT_FULL;
        end
      end
      hfl_pkg::MODE_RELEASE, hfl_pkg::MODE_QUERY: begin
        if (r.handle == 0 || r.handle > issued_hw || r.handle > MAX_H) begin
          o.status = hfl_pkg::STAT_RANGE;
        end else if (!live_map[r.handle - 1]) begin
          o.status = hfl_pkg::STAT_DEAD;
        end else if (r.mode == hfl_pkg::MODE_RELEASE && lifo_depth >= MAX_H) begin
          o.status = hfl_pkg::STAT_FULL;
        end else begin
          if (r.mode == hfl_pkg::MODE_RELEASE) begin
            live_map[r.handle - 1] = 1'b0;
            free_lifo[lifo_depth] = r.handle;
            lifo_depth++;
          end
          o.handle = r.handle;
          o.ok = 1'b1;
          o.status = hfl_pkg::STAT_OK;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    err_count++;
    $display("t=%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Request driver: a transaction stays on the bus until it is taken.
  always @(negedge clk_i) begin
    handle_req_t nxt;
    if (!req_ch.valid || req_fired) begin
      if (req_backlog.size() != 0 && (steady_run || $urandom_range(99) >= 33)) begin
        nxt = req_backlog.pop_front();
        req_ch.valid          <= 1'b1;
        req_ch.mode           <= nxt.mode;
        req_ch.handle         <= nxt.handle;
        req_ch.template_valid <= nxt.tmpl;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    rsp_ch.ready <= steady_run || ($urandom_range(99) >= 33);
  end

  // Monitor: the response is checked before the same edge's request is predicted, since
  // any response leaving now belongs to an earlier request.
  always @(posedge clk_i) begin
    handle_req_t r;
    handle_rsp_t want;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("response with no request outstanding", rsp_ch.handle_out, 0);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_ch.handle_out !== want.handle)
            report_mismatch("handle_out", rsp_ch.handle_out, want.handle);
          if (rsp_ch.ok !== want.ok)
            report_mismatch("ok", rsp_ch.ok, want.ok);
          if (rsp_ch.status !== want.status)
            report_mismatch("status", rsp_ch.status, want.status);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        capacity_reg = cfg_ch.data;
      end
      if (req_ch.valid && req_ch.ready) begin
        r.mode   = req_ch.mode;
        r.handle = req_ch.handle;
        r.tmpl   = req_ch.template_valid;
        awaited_rsp = {awaited_rsp, apply_handle_op(r)};
      end
    end
    req_fired <= rst_ni && req_ch.valid && req_ch.ready;
  end

  task automatic queue_req(logic [hfl_pkg::MODE_W-1:0] mode,
                           logic [hfl_pkg::HANDLE_W-1:0] handle, logic tmpl);
    handle_req_t r;
    r.mode   = mode;
    r.handle = handle;
    r.tmpl   = tmpl;
    req_backlog = {req_backlog, r};
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_ch.valid || awaited_rsp.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
  endtask

  task automatic set_capacity(logic [hfl_pkg::CAP_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly meaningful traffic: releases and queries aim at handles issued so far, with a
  // thin layer of arbitrary requests on top. The backlog is kept short so that the issue
  // count seen here stays close to the block's.
  task automatic feed_random(int unsigned count, int unsigned alloc_pct);
    handle_req_t r;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      while (req_backlog.size() >= 2) begin
        @(posedge clk_i);
        #1;
      end
      pick     = $urandom_range(99);
      r.tmpl   = ($urandom_range(9) != 0);
      r.handle = hfl_pkg::HANDLE_W'($urandom_range(511));
      if (pick < alloc_pct) begin
        r.mode = hfl_pkg::MODE_ALLOC;
      end else if (pick < 96) begin
        r.mode = ($urandom_range(2) == 0) ? hfl_pkg::MODE_QUERY : hfl_pkg::MODE_RELEASE;
        if (issued_hw > 0 && $urandom_range(99) < 85)
          r.handle = hfl_pkg::HANDLE_W'($urandom_range(issued_hw, 1));
      end else begin
        r.mode = hfl_pkg::MODE_W'($urandom_range(3));
        r.tmpl = 1'($urandom_range(1));
      end
      req_backlog = {req_backlog, r};
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    req_ch.valid          = 1'b0;
    req_ch.mode           = hfl_pkg::MODE_ALLOC;
    req_ch.handle         = '0;
    req_ch.template_valid = 1'b0;
    rsp_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.data           = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero capacity: nothing can be issued, and a missing template is reported first.
    set_capacity('0);
    queue_req(hfl_pkg::MODE_ALLOC, 9'd0, 1'b1);
    queue_req(hfl_pkg::MODE_ALLOC, 9'd0, 1'b0);
    queue_req(hfl_pkg::MODE_RELEASE, 9'd0, 1'b1);
    queue_req(hfl_pkg::MODE_QUERY, 9'd1, 1'b1);
    queue_req(MODE_SPARE, 9'd5, 1'b1);
    queue_req(hfl_pkg::MODE_QUERY, 9'd511, 1'b0);
    queue_req(hfl_pkg::MODE_RELEASE, 9'd256, 1'b1);

    // Two handles: fill up, double release, and reuse in last-in first-out order.
    set_capacity(9'd2);
    queue_req(hfl_pkg::MODE_ALLOC, 9'd511, 1'b1);
    queue_req(hfl_pkg::MODE_ALLOC, 9'd0, 1'b1);
    queue_req(hfl_pkg::MODE_ALLOC, 9'd0, 1'b1);
    queue_req(hfl_pkg::MODE_QUERY, 9'd1, 1'b0);
    queue_req(hfl_pkg::MODE_RELEASE, 9'd2, 1'b0);
    queue_req(hfl_pkg::MODE_RELEASE, 9'd2, 1'b1);
    queue_req(hfl_pkg::MODE_QUERY, 9'd2, 1'b1);
    queue_req(hfl_pkg::MODE_ALLOC, 9'd0, 1'b1);
    queue_req(hfl_pkg::MODE_RELEASE, 9'd1, 1'b1);
    queue_req(hfl_pkg::MODE_RELEASE, 9'd2, 1'b1);
    queue_req(hfl_pkg::MODE_ALLOC, 9'd0, 1'b1);
    queue_req(hfl_pkg::MODE_ALLOC, 9'd0, 1'b1);
    queue_req(hfl_pkg::MODE_QUERY, 9'd3, 1'b1);

    set_capacity(hfl_pkg::CAP_W'($urandom_range(40, 3)));
    feed_random(200, 50);

    // Capacity now sits below the issue count; issued handles must stay usable.
    set_capacity(9'd1);
    feed_random(100, 40);

    // Saturating capacity with allocation-heavy traffic and no idling on either side.
    set_capacity(9'd511);
    steady_run = 1'b1;
    feed_random(320, 88);
    wait_drained();
    steady_run = 1'b0;

    set_capacity(9'd256);
    feed_random(150, 45);
    wait_drained();
    feed_random(150, 45);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("handle_free_list_allocator_tb: done, clean");
    end else begin
      $display("handle_free_list_allocator_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("handle_free_list_allocator_tb: done, errors");
    $finish;
  end

endmodule
